/* src/lfu_pkg.sv */
`default_nettype none
package lfu_pkg;

   // one slot as it sits in the slot memory
   typedef struct packed {
      logic        valid;
      logic [31:0] key;
      logic [31:0] data;
      logic [31:0] use_count;
      logic [31:0] last_touch;
   } entry_type;

   localparam int ENTRY_W = $bits(entry_type);

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_SCAN,
      ST_LAST,
      ST_WRITE
   } state_type;

   localparam logic        CMD_GET        = 1'b0;
   localparam logic        CMD_PUT        = 1'b1;
   localparam logic [31:0] MISS_VALUE     = 32'hFFFF_FFFF;
   localparam logic [31:0] COUNT_MAX      = 32'hFFFF_FFFF;
   localparam logic [31:0] COUNT_NEW      = 32'd1;
   localparam logic [4:0]  CAP_RESET      = 5'd16;

endpackage
`default_nettype wire

/* src/lfu_req_if.sv */
`default_nettype none
interface lfu_req_if;
   logic               valid;
   logic               ready;
   logic               cmd;
   logic signed [31:0] lookup_key;
   logic signed [31:0] write_value;

   modport source (output valid, cmd, lookup_key, write_value, input ready);
   modport sink   (input valid, cmd, lookup_key, write_value, output ready);
endinterface
`default_nettype wire

/* src/lfu_rsp_if.sv */
`default_nettype none
interface lfu_rsp_if;
   logic               valid;
   logic               ready;
   logic               hit;
   logic signed [31:0] read_value;
   logic               evicted;
   logic signed [31:0] evicted_key;

   modport source (output valid, hit, read_value, evicted, evicted_key, input ready);
   modport sink   (input valid, hit, read_value, evicted, evicted_key, output ready);
endinterface
`default_nettype wire

/* src/lfu_csr_if.sv */
`default_nettype none
interface lfu_csr_if;
   logic       valid;
   logic       ready;
   logic [4:0] capacity_in_use;

   modport source (output valid, capacity_in_use, input ready);
   modport sink   (input valid, capacity_in_use, output ready);
endinterface
`default_nettype wire

/* src/lfu_ram.sv */
`default_nettype none
module lfu_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic                  clock,
   input  wire logic                  we,
   input  wire logic [AW-1:0]         waddr,
   input  wire logic [WIDTH-1:0]      wdata,
   input  wire logic                  re,
   input  wire logic [AW-1:0]         raddr,
   output logic      [WIDTH-1:0]      rdata
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;
endmodule
`default_nettype wire

/* src/lfu_cache_replacement_core.sv */
`default_nettype none
// LFU key-value store with least-recently-used tie break. Each req item is a
// get or a put of a 32-bit key; each produces exactly one rsp item (hit,
// read_value, evicted, evicted_key). All slots live in one synchronous RAM
// with one read and one write port. No new item is taken until the last
// one is through: an idle state accepts it, a scan state walks every slot
// through the read port one per cycle (key match, first free slot,
// victim by lowest use count then oldest touch), a last state folds in the
// final read, and a write-back state also loads the rsp register.
// The write-back waits only if the previous result is still untaken. After
// reset a clearing pass marks every slot invalid; no req item is taken
// meanwhile. The csr channel is always ready; capacity_in_use
// above CAPACITY acts as CAPACITY, and zero makes puts of new keys no-ops.
module lfu_cache_replacement_core
   import lfu_pkg::*;
#(
   parameter int CAPACITY = 16
) (
   input  wire logic clock,
   input  wire logic reset,
   lfu_req_if.sink   req_ch,
   lfu_rsp_if.source rsp_ch,
   lfu_csr_if.sink   csr_ch
);
   localparam int AW   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int UW   = $clog2(CAPACITY + 1);
   localparam int CMPW = (UW > 5) ? UW : 5;
   localparam logic [AW-1:0]   LAST_ADDR = AW'(CAPACITY - 1);
   localparam logic [CMPW-1:0] CAP_MAX   = CMPW'(CAPACITY);

   state_type state_ff, state_in;

   // slot walk
   logic [AW-1:0] addr_ff;
   logic          rd_pend_ff;
   logic [AW-1:0] rd_idx_ff;
   logic          addr_last;

   // item being worked on
   logic        cmd_ff;
   logic [31:0] key_ff;
   logic [31:0] val_ff;

   logic [4:0]  cap_ff;
   logic [31:0] tc_ff;

   // scan results
   logic [UW-1:0] used_ff;
   logic          found_vld_ff;
   logic [AW-1:0] found_idx_ff;
   logic [31:0]   found_data_ff;
   logic [31:0]   found_cnt_ff;
   logic          free_vld_ff;
   logic [AW-1:0] free_idx_ff;
   logic          vic_vld_ff;
   logic [AW-1:0] vic_idx_ff;
   logic [31:0]   vic_key_ff;
   logic [31:0]   vic_cnt_ff;
   logic [31:0]   vic_age_ff;

   // result register
   logic        rsp_valid_ff;
   logic        rsp_hit_ff;
   logic [31:0] rsp_read_ff;
   logic        rsp_ev_ff;
   logic [31:0] rsp_evk_ff;

   // RAM port signals
   logic               ram_we;
   logic [AW-1:0]      ram_waddr;
   logic [ENTRY_W-1:0] ram_wdata;
   logic               ram_re;
   logic [ENTRY_W-1:0] ram_rdata;

   entry_type   rd_entry;
   logic [31:0] rd_age;
   logic        rd_better;

   // write-back decision
   logic          out_free;
   logic          req_fire;
   logic          wr_do;
   logic [AW-1:0] wr_idx;
   entry_type     wr_entry;
   logic          res_hit;
   logic [31:0]   res_read;
   logic          res_ev;
   logic [31:0]   res_evk;
   logic [31:0]   cnt_bumped;
   logic [CMPW-1:0] cap_ext, cap_eff, used_ext;

   lfu_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (CAPACITY)
   ) u_slots (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .re    (ram_re),
      .raddr (addr_ff),
      .rdata (ram_rdata)
   );

   assign addr_last = (addr_ff == LAST_ADDR);
   assign out_free  = !rsp_valid_ff || rsp_ch.ready;
   assign req_fire  = req_ch.valid && req_ch.ready;

   // ---- per-slot compare on the word just read
   assign rd_entry = entry_type'(ram_rdata);
   assign rd_age   = tc_ff - rd_entry.last_touch;  // modulo 2^32 age, larger is older
   assign rd_better = rd_entry.valid &&
                      (!vic_vld_ff || (rd_entry.use_count < vic_cnt_ff) ||
                       ((rd_entry.use_count == vic_cnt_ff) && (rd_age > vic_age_ff)));

   // ---- next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR: if (addr_last) state_in = ST_IDLE;
         ST_IDLE:  if (req_fire) state_in = ST_SCAN;
         ST_SCAN:  if (addr_last) state_in = ST_LAST;
         ST_LAST:  state_in = ST_WRITE;
         ST_WRITE: if (out_free) state_in = ST_IDLE;
         default:  state_in = ST_CLEAR;
      endcase
   end

   // ---- write-back decision, from the scan results
   always_comb begin
      cap_ext  = CMPW'(cap_ff);
      cap_eff  = (cap_ext > CAP_MAX) ? CAP_MAX : cap_ext;
      used_ext = CMPW'(used_ff);
      cnt_bumped = (found_cnt_ff == COUNT_MAX) ? found_cnt_ff : found_cnt_ff + 32'd1;

      wr_do    = 1'b0;
      wr_idx   = found_idx_ff;
      wr_entry = '{valid: 1'b1, key: key_ff, data: val_ff,
                   use_count: COUNT_NEW, last_touch: tc_ff};
      res_hit  = 1'b0;
      res_read = 32'd0;
      res_ev   = 1'b0;
      res_evk  = 32'd0;

      if (cmd_ff == CMD_GET) begin
         if (found_vld_ff) begin
            res_hit  = 1'b1;
            res_read = found_data_ff;
            wr_do    = 1'b1;
            wr_entry.data      = found_data_ff;
            wr_entry.use_count = cnt_bumped;
         end else begin
            res_read = MISS_VALUE;
         end
      end else if (found_vld_ff) begin
         res_hit  = 1'b1;
         wr_do    = 1'b1;
         wr_entry.use_count = cnt_bumped;
      end else if (cap_eff != '0) begin
         if ((used_ext >= cap_eff) || !free_vld_ff) begin
            // full: replace the victim, if there is any entry at all
            wr_do   = vic_vld_ff;
            wr_idx  = vic_idx_ff;
            res_ev  = vic_vld_ff;
            res_evk = vic_vld_ff ? vic_key_ff : 32'd0;
         end else begin
            wr_do  = 1'b1;
            wr_idx = free_idx_ff;
         end
      end
   end

   // ---- outputs of the state machine
   always_comb begin
      req_ch.ready = 1'b0;
      ram_re       = 1'b0;
      ram_we       = 1'b0;
      ram_waddr    = addr_ff;
      ram_wdata    = '0;
      unique case (state_ff)
         ST_CLEAR: begin
            ram_we    = 1'b1;
            ram_wdata = '0;
         end
         ST_IDLE: begin
            req_ch.ready = 1'b1;
         end
         ST_SCAN: begin
            ram_re = 1'b1;
         end
         ST_LAST: begin
            ram_re = 1'b0;
         end
         ST_WRITE: begin
            ram_we    = out_free && wr_do;
            ram_waddr = wr_idx;
            ram_wdata = wr_entry;
         end
         default: begin
            ram_re = 1'b0;
         end
      endcase
   end

   assign csr_ch.ready = 1'b1;

   // ---- control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         addr_ff      <= '0;
         rd_pend_ff   <= 1'b0;
         cap_ff       <= CAP_RESET;
         tc_ff        <= '0;
         rsp_valid_ff <= 1'b0;
         used_ff      <= '0;
         found_vld_ff <= 1'b0;
         free_vld_ff  <= 1'b0;
         vic_vld_ff   <= 1'b0;
      end else begin
         state_ff   <= state_in;
         rd_pend_ff <= (state_ff == ST_SCAN);

         if ((state_ff == ST_CLEAR) || (state_ff == ST_SCAN)) begin
            addr_ff <= addr_last ? '0 : addr_ff + AW'(1);
         end else begin
            addr_ff <= '0;
         end

         if (csr_ch.valid && csr_ch.ready) begin
            cap_ff <= csr_ch.capacity_in_use;
         end

         if (req_fire) begin
            used_ff      <= '0;
            found_vld_ff <= 1'b0;
            free_vld_ff  <= 1'b0;
            vic_vld_ff   <= 1'b0;
         end else if (rd_pend_ff) begin
            if (rd_entry.valid) begin
               used_ff <= used_ff + UW'(1);
               if (!found_vld_ff && (rd_entry.key == key_ff)) begin
                  found_vld_ff <= 1'b1;
               end
            end else if (!free_vld_ff) begin
               free_vld_ff <= 1'b1;
            end
            if (rd_better) begin
               vic_vld_ff <= 1'b1;
            end
         end

         if ((state_ff == ST_WRITE) && out_free) begin
            rsp_valid_ff <= 1'b1;
            if (wr_do) begin
               tc_ff <= tc_ff + 32'd1;
            end
         end else if (rsp_ch.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // ---- payload registers
   always_ff @(posedge clock) begin
      rd_idx_ff <= addr_ff;
      if (req_fire) begin
         cmd_ff <= req_ch.cmd;
         key_ff <= req_ch.lookup_key;
         val_ff <= req_ch.write_value;
      end
      if (rd_pend_ff) begin
         if (rd_entry.valid && !found_vld_ff && (rd_entry.key == key_ff)) begin
            found_idx_ff  <= rd_idx_ff;
            found_data_ff <= rd_entry.data;
            found_cnt_ff  <= rd_entry.use_count;
         end
         if (!rd_entry.valid && !free_vld_ff) begin
            free_idx_ff <= rd_idx_ff;
         end
         if (rd_better) begin
            vic_idx_ff <= rd_idx_ff;
            vic_key_ff <= rd_entry.key;
            vic_cnt_ff <= rd_entry.use_count;
            vic_age_ff <= rd_age;
         end
      end
      if ((state_ff == ST_WRITE) && out_free) begin
         rsp_hit_ff  <= res_hit;
         rsp_read_ff <= res_read;
         rsp_ev_ff   <= res_ev;
         rsp_evk_ff  <= res_evk;
      end
   end

   assign rsp_ch.valid       = rsp_valid_ff;
   assign rsp_ch.hit         = rsp_hit_ff;
   assign rsp_ch.read_value  = rsp_read_ff;
   assign rsp_ch.evicted     = rsp_ev_ff;
   assign rsp_ch.evicted_key = rsp_evk_ff;

`ifndef SYNTH
   // a new result only ever comes out of the write-back step
   a_rsp_from_write: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_WRITE))
      else $error("rsp valid rose outside write-back");

   // an eviction is never reported together with a hit
   a_evict_no_hit: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ev_ff) |-> !rsp_hit_ff)
      else $error("evicted and hit both set");

   // the touch clock moves only when a slot is written back
   a_tc_on_write: assert property (@(posedge clock) disable iff (reset)
      (tc_ff != $past(tc_ff)) |-> $past((state_ff == ST_WRITE) && ram_we))
      else $error("touch clock moved without a slot write");
`endif

endmodule
`default_nettype wire

/* sim/tb_lfu_cache_replacement_core.sv */
`timescale 1ns / 1ps
module tb_lfu_cache_replacement_core
   import lfu_pkg::*;
;

   localparam int          SLOTS      = 16;
   // slowest run: ~1100 items, each with its busy time, longest send gap and
   // longest rsp stall, plus one long hold and the clearing pass, then taken about four times over
   localparam int          LIMIT      = 600_000;
   localparam int          LONG_HOLD  = 400;
   localparam int          PRINT_MAX  = 100;
   localparam logic [31:0] KEY_MIN    = 32'h8000_0000;
   localparam logic [31:0] KEY_MAX    = 32'h7FFF_FFFF;
   localparam logic [31:0] KEY_ZERO   = 32'h0000_0000;

   typedef struct packed {
      logic        hit;
      logic [31:0] read_value;
      logic        evicted;
      logic [31:0] evicted_key;
   } outcome_type;

   logic clock = 1'b0;
   logic reset;

   lfu_req_if req_ch ();
   lfu_rsp_if rsp_ch ();
   lfu_csr_if csr_ch ();

   lfu_cache_replacement_core #(
      .CAPACITY (SLOTS)
   ) dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // ------------------------------------------------------------------
   // Shadow copy of the store. Updated in accept order, so each accepted
   // item yields exactly one outcome pushed to pending_rsp.
   // ------------------------------------------------------------------
   logic        mirror_live  [SLOTS];
   logic [31:0] mirror_key   [SLOTS];
   logic [31:0] mirror_val   [SLOTS];
   logic [31:0] mirror_uses  [SLOTS];
   logic [31:0] mirror_stamp [SLOTS];
   logic [31:0] mirror_tick;
   logic [4:0]  mirror_cap;

   outcome_type pending_rsp [$];
   logic [31:0] key_pool [$];

   int unsigned error_count = 0;
   int unsigned cycle_count = 0;
   bit          send_steady = 0;   // no gaps on the req side
   bit          rsp_steady  = 0;   // no stalls on the rsp side
   bit          hold_off_req = 0;  // asks the rsp side for one long hold

   // LFU access with LRU tie break; mutates the shadow store
   function automatic outcome_type predict_access(logic op, logic [31:0] key,
                                                  logic [31:0] val);
      outcome_type o;
      int          hit_slot, free_slot, fill;
      int unsigned used;
      logic [31:0] cap_eff, age, best_age, best_uses;
      o         = '0;
      hit_slot  = -1;
      free_slot = -1;
      used      = 0;
      cap_eff   = (mirror_cap > SLOTS) ? SLOTS : mirror_cap;
      for (int i = 0; i < SLOTS; i++) begin
         if (mirror_live[i]) begin
            used++;
            if (hit_slot < 0 && mirror_key[i] == key) hit_slot = i;
         end else if (free_slot < 0) begin
            free_slot = i;
         end
      end
      if (hit_slot >= 0) begin
         o.hit = 1'b1;
         if (op == CMD_PUT) mirror_val[hit_slot] = val;
         else o.read_value = mirror_val[hit_slot];
         if (mirror_uses[hit_slot] != COUNT_MAX)
            mirror_uses[hit_slot] = mirror_uses[hit_slot] + 1;
         mirror_stamp[hit_slot] = mirror_tick;
         mirror_tick = mirror_tick + 1;
      end else if (op == CMD_GET) begin
         o.read_value = MISS_VALUE;
      end else if (cap_eff != 0) begin
         fill = free_slot;
         if (used >= cap_eff || fill < 0) begin
            // victim: lowest count, then largest age, then lowest index
            fill      = -1;
            best_age  = '0;
            best_uses = '0;
            for (int i = 0; i < SLOTS; i++) begin
               if (mirror_live[i]) begin
                  age = mirror_tick - mirror_stamp[i];
                  if (fill < 0 || mirror_uses[i] < best_uses ||
                      (mirror_uses[i] == best_uses && age > best_age)) begin
                     fill      = i;
                     best_uses = mirror_uses[i];
                     best_age  = age;
                  end
               end
            end
            if (fill >= 0) begin
               o.evicted     = 1'b1;
               o.evicted_key = mirror_key[fill];
            end
         end
         if (fill >= 0) begin
            mirror_live[fill]  = 1'b1;
            mirror_key[fill]   = key;
            mirror_val[fill]   = val;
            mirror_uses[fill]  = COUNT_NEW;
            mirror_stamp[fill] = mirror_tick;
            mirror_tick = mirror_tick + 1;
         end
      end
      return o;
   endfunction

   // gap length: mostly short, now and then long
   function automatic int unsigned pick_idle();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 70) return $urandom_range(0, 2);
      else if (r < 95) return $urandom_range(3, 8);
      else return $urandom_range(20, 60);
   endfunction

   task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
      // print is capped so a dead block cannot flood the log; all are counted
      if (error_count < PRINT_MAX)
         $display("%0t mismatch %s: got %h want %h", $time, what, got, want);
      error_count++;
   endtask

   // ------------------------------------------------------------------
   // req side: one item per call; valid stays high after accept so the
   // next call can follow back to back
   // ------------------------------------------------------------------
   task automatic send_item(logic op, logic [31:0] key, logic [31:0] val);
      int unsigned idle_len;
      idle_len = send_steady ? 0 : ($urandom_range(0, 2) == 0 ? pick_idle() : 0);
      @(negedge clock);
      if (idle_len > 0) begin
         req_ch.valid <= 1'b0;
         repeat (idle_len) @(negedge clock);
      end
      req_ch.valid       <= 1'b1;
      req_ch.cmd         <= op;
      req_ch.lookup_key  <= key;
      req_ch.write_value <= val;
      do @(posedge clock); while (req_ch.ready !== 1'b1);
      pending_rsp.push_back(predict_access(op, key, val));
   endtask

   // stop offering and wait until every outstanding result is back
   task automatic settle_idle();
      @(negedge clock);
      req_ch.valid <= 1'b0;
      while (pending_rsp.size() != 0) @(posedge clock);
   endtask

   task automatic write_capacity(logic [4:0] cap);
      settle_idle();
      @(negedge clock);
      csr_ch.valid           <= 1'b1;
      csr_ch.capacity_in_use <= cap;
      do @(posedge clock); while (csr_ch.ready !== 1'b1);
      mirror_cap = cap;
      @(negedge clock);
      csr_ch.valid <= 1'b0;
   endtask

   // keys drawn from a small pool so that hits and evictions are common
   task automatic fill_key_pool(int unsigned n);
      key_pool.delete();
      key_pool.push_back(KEY_MIN);
      key_pool.push_back(KEY_MAX);
      for (int unsigned i = 2; i < n; i++) key_pool.push_back($urandom);
   endtask

   function automatic logic [31:0] pick_key();
      if ($urandom_range(0, 9) == 0) return $urandom;
      return key_pool[$urandom_range(0, key_pool.size() - 1)];
   endfunction

   // ------------------------------------------------------------------
   // rsp side: random stalls, optional steady stretch, and one long hold
   // counted here on request
   // ------------------------------------------------------------------
   initial begin
      int unsigned stall_left;
      int unsigned hold_left;
      stall_left = 0;
      hold_left  = 0;
      rsp_ch.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_off_req) begin
            hold_left    = LONG_HOLD;
            hold_off_req = 0;
         end
         if (hold_left > 0) begin
            rsp_ch.ready <= 1'b0;
            hold_left--;
         end else if (stall_left > 0 && !rsp_steady) begin
            rsp_ch.ready <= 1'b0;
            stall_left--;
         end else begin
            rsp_ch.ready <= 1'b1;
            stall_left = (!rsp_steady && $urandom_range(0, 3) == 0) ? pick_idle() : 0;
         end
      end
   end

   // result checker: oldest outcome against each accepted rsp item
   always @(posedge clock) begin
      outcome_type want;
      if (!reset && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
         if (pending_rsp.size() == 0) begin
            report_mismatch("unexpected rsp item, key", rsp_ch.evicted_key, '0);
         end else begin
            want = pending_rsp.pop_front();
            if (rsp_ch.hit !== want.hit)
               report_mismatch("hit", rsp_ch.hit, want.hit);
            if (rsp_ch.read_value !== want.read_value)
               report_mismatch("read_value", rsp_ch.read_value, want.read_value);
            if (rsp_ch.evicted !== want.evicted)
               report_mismatch("evicted", rsp_ch.evicted, want.evicted);
            if (rsp_ch.evicted_key !== want.evicted_key)
               report_mismatch("evicted_key", rsp_ch.evicted_key, want.evicted_key);
         end
      end
   end

   // watchdog
   initial begin
      while (cycle_count < LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("TEST FAILED");
      $finish;
   end

   // ------------------------------------------------------------------
   // tests
   // ------------------------------------------------------------------

   // empty store: every get misses with the all-ones value
   task automatic test_empty_lookup();
      send_item(CMD_GET, KEY_MIN, KEY_MAX);
      send_item(CMD_GET, KEY_MAX, KEY_MIN);
   endtask

   // extreme keys and values, update in place, stored all-ones value on a hit
   task automatic test_put_get_extremes();
      send_item(CMD_PUT, KEY_MAX, KEY_MIN);
      send_item(CMD_PUT, KEY_MIN, KEY_MAX);
      send_item(CMD_PUT, KEY_ZERO, MISS_VALUE);
      send_item(CMD_GET, KEY_MAX, '0);
      send_item(CMD_GET, KEY_MIN, '0);
      send_item(CMD_GET, KEY_ZERO, '1);
      send_item(CMD_PUT, KEY_MAX, KEY_ZERO);
      send_item(CMD_GET, KEY_MAX, '0);
   endtask

   // capacity dropped below occupancy, then count order and recency tie break
   task automatic test_lfu_eviction();
      write_capacity(5'd2);
      send_item(CMD_PUT, 32'h0000_00A1, 32'h1111_1111);  // evicts, occupancy kept
      send_item(CMD_GET, 32'h0000_00A1, '0);
      send_item(CMD_PUT, 32'h0000_00B2, 32'h2222_2222);
      send_item(CMD_GET, 32'h0000_00B2, '0);
      send_item(CMD_GET, 32'h0000_00B2, '0);
      send_item(CMD_PUT, 32'h0000_00C3, 32'h3333_3333);
   endtask

   // zero capacity: new keys are dropped, present keys still hit
   task automatic test_zero_capacity();
      write_capacity(5'd0);
      send_item(CMD_PUT, 32'h0000_00D4, 32'h4444_4444);
      send_item(CMD_GET, 32'h0000_00D4, '0);
      send_item(CMD_GET, 32'h0000_00B2, '0);
      send_item(CMD_PUT, 32'h0000_00B2, 32'h5555_5555);
   endtask

   task automatic run_random_phase(logic [4:0] cap, int unsigned n_items, bit steady);
      int unsigned cap_eff;
      write_capacity(cap);
      cap_eff = (cap > SLOTS) ? SLOTS : cap;
      fill_key_pool(cap_eff + 6);
      send_steady = steady;
      rsp_steady  = steady;
      for (int unsigned i = 0; i < n_items; i++)
         send_item($urandom_range(0, 1) ? CMD_PUT : CMD_GET, pick_key(), $urandom);
      send_steady = 0;
      rsp_steady  = 0;
   endtask

   // several capacities: above the slot count, full, small, one, zero, all bits set
   task automatic test_random_traffic();
      run_random_phase(5'd31, 130, 0);
      run_random_phase(5'd16, 130, 1);
      run_random_phase(5'd5,  130, 0);
      run_random_phase(5'd1,  110, 0);
      run_random_phase(5'd0,   60, 0);
      run_random_phase(5'd12, 130, 0);
      run_random_phase(5'd17, 130, 0);
      run_random_phase(5'd8,  130, 0);
   endtask

   // rsp side holds off for a long stretch while items keep coming; the
   // single rsp register fills and req must stall
   task automatic test_backpressure();
      write_capacity(CAP_RESET);
      fill_key_pool(20);
      hold_off_req = 1;
      send_steady  = 1;
      for (int unsigned i = 0; i < 40; i++)
         send_item($urandom_range(0, 1) ? CMD_PUT : CMD_GET, pick_key(), $urandom);
      send_steady = 0;
   endtask

   initial begin
      reset                  = 1'b1;
      req_ch.valid           = 1'b0;
      req_ch.cmd             = CMD_GET;
      req_ch.lookup_key      = '0;
      req_ch.write_value     = '0;
      csr_ch.valid           = 1'b0;
      csr_ch.capacity_in_use = CAP_RESET;
      for (int i = 0; i < SLOTS; i++) begin
         mirror_live[i]  = 1'b0;
         mirror_key[i]   = '0;
         mirror_val[i]   = '0;
         mirror_uses[i]  = '0;
         mirror_stamp[i] = '0;
      end
      mirror_tick = '0;
      mirror_cap  = CAP_RESET;

      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_empty_lookup();
      test_put_get_extremes();
      test_lfu_eviction();
      test_zero_capacity();
      test_random_traffic();
      test_backpressure();

      settle_idle();
      repeat (SLOTS + 8) @(posedge clock);
      if (error_count == 0 && pending_rsp.size() == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
